FILE: design/size_class_block_allocator_top_macros.svh
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SCBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scba assertion failed");
`define SCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scba assertion failed");
`else
`define SCBA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/scba_pkg.sv
package scba_pkg;

	localparam int NUM_CLASSES      = 4;
	localparam int CLS_W            = $clog2(NUM_CLASSES);
	localparam int SIZE_W           = 32;
	localparam int HANDLE_W         = 10;
	localparam int CNT_W            = 3;
	localparam int LEN_W            = 11;
	localparam int CFG_IDX_W        = 3;
	localparam int DEF_MAX_ENTRIES  = 1024;
	localparam int DEF_REFILL_COUNT = 128;

	localparam logic [LEN_W-1:0]  LEN_MAX    = {LEN_W{1'b1}};
	localparam logic [SIZE_W-1:0] NEVER_SIZE = {SIZE_W{1'b1}};

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_NO_FIT     = 2'd1;
	localparam logic [1:0] STAT_EXHAUSTED  = 2'd2;
	localparam logic [1:0] STAT_BAD_HANDLE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLASS_SIZE_0 = 3'd1;

	typedef logic [NUM_CLASSES-1:0][SIZE_W-1:0] size_vec_t;

	localparam logic [CNT_W-1:0] CLASS_COUNT_RST = 3'd4;
	localparam size_vec_t CLASS_SIZE_RST = {32'd4096, 32'd1024, 32'd256, 32'd64};

	typedef struct packed {
		logic              vld;
		logic [CLS_W-1:0]  cls;
		logic [SIZE_W-1:0] size;
	} cand_t;

	typedef struct packed {
		logic link_we;
		logic cls_we;
	} mem_ctl_t;

endpackage

FILE: design/scba_select.sv
module scba_select (
	input  logic                   clk,
	input  logic [31:0]            request_size,
	input  logic [2:0]             class_count,
	input  scba_pkg::size_vec_t    class_sizes,
	output scba_pkg::cand_t        pick
);
	import scba_pkg::*;

	localparam int PAIRS = NUM_CLASSES / 2;

	logic [NUM_CLASSES-1:0] fit_s1;
	cand_t                  pair_s2 [PAIRS];
	logic                   take_hi;

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CLASSES; i++) begin
			fit_s1[i] <= (CNT_W'(i) < class_count) && (class_sizes[i] > request_size) &&
				(class_sizes[i] != NEVER_SIZE);
		end
		for (int p = 0; p < PAIRS; p++) begin
			if (fit_s1[2*p+1] && (!fit_s1[2*p] || class_sizes[2*p+1] < class_sizes[2*p])) begin
				pair_s2[p].cls  <= CLS_W'(2*p+1);
				pair_s2[p].size <= class_sizes[2*p+1];
			end else begin
				pair_s2[p].cls  <= CLS_W'(2*p);
				pair_s2[p].size <= class_sizes[2*p];
			end
			pair_s2[p].vld <= fit_s1[2*p] | fit_s1[2*p+1];
		end
	end

	// ties go to the lower pair
	assign take_hi = pair_s2[1].vld && (!pair_s2[0].vld || pair_s2[1].size < pair_s2[0].size);
	assign pick    = take_hi ? pair_s2[1] : pair_s2[0];

endmodule

FILE: design/scba_store.sv
module scba_store #(
	parameter int MAX_ENTRIES = scba_pkg::DEF_MAX_ENTRIES,
	parameter int HW          = $clog2(MAX_ENTRIES)
) (
	input  logic                          clk,
	input  scba_pkg::mem_ctl_t            mem_ctl,
	input  logic [HW-1:0]                 link_waddr,
	input  logic [HW-1:0]                 link_wdata,
	input  logic [HW-1:0]                 link_raddr,
	output logic [HW-1:0]                 link_rd,
	input  logic [HW-1:0]                 cls_waddr,
	input  logic [scba_pkg::CLS_W-1:0]    cls_wdata,
	input  logic [HW-1:0]                 cls_raddr,
	output logic [scba_pkg::CLS_W-1:0]    cls_rd
);
	import scba_pkg::*;

	logic [HW-1:0]    link_mem [MAX_ENTRIES];
	logic [CLS_W-1:0] cls_mem  [MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (mem_ctl.link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		link_rd <= link_mem[link_raddr];
	end

	always_ff @(posedge clk) begin
		if (mem_ctl.cls_we) begin
			cls_mem[cls_waddr] <= cls_wdata;
		end
		cls_rd <= cls_mem[cls_raddr];
	end

endmodule

FILE: design/scba_ctrl.sv
module scba_ctrl #(
	parameter int MAX_ENTRIES  = scba_pkg::DEF_MAX_ENTRIES,
	parameter int REFILL_COUNT = scba_pkg::DEF_REFILL_COUNT,
	parameter int HW           = $clog2(MAX_ENTRIES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          command,
	input  logic [9:0]                    block_handle,
	input  scba_pkg::size_vec_t           class_sizes,
	input  scba_pkg::cand_t               pick,
	input  logic [HW-1:0]                 link_rd,
	input  logic [scba_pkg::CLS_W-1:0]    cls_rd,
	output logic                          busy,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [9:0]                    handle_out,
	output logic [1:0]                    class_index,
	output logic [31:0]                   class_size,
	output scba_pkg::mem_ctl_t            mem_ctl,
	output logic [HW-1:0]                 link_waddr,
	output logic [HW-1:0]                 link_wdata,
	output logic [HW-1:0]                 link_raddr,
	output logic [HW-1:0]                 cls_waddr,
	output logic [scba_pkg::CLS_W-1:0]    cls_wdata,
	output logic [HW-1:0]                 cls_raddr
);
	import scba_pkg::*;

	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int RW   = $clog2(REFILL_COUNT + 1);
	localparam int CMPW = (CW > HANDLE_W) ? CW : HANDLE_W;
	localparam int MW   = (CW > RW) ? CW : RW;

	typedef enum logic [2:0] {
		S_IDLE, S_FREE_CHK, S_SEL1, S_SEL2, S_DECIDE, S_REFILL, S_POP
	} state_t;

	state_t            state_q;
	logic [HW-1:0]     head_q [NUM_CLASSES];
	logic [HW-1:0]     tail_q [NUM_CLASSES];
	logic [LEN_W-1:0]  len_q  [NUM_CLASSES];
	logic [CW-1:0]     carved_q;
	logic [RW-1:0]     rem_q;
	logic [CMPW-1:0]   hin_q;
	logic              found_q;
	logic [CLS_W-1:0]  cls_q;
	logic [SIZE_W-1:0] best_q;
	logic              done_q;
	logic [1:0]        status_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [CLS_W-1:0]  class_q;
	logic [SIZE_W-1:0] size_q;

	logic              bad_handle;
	logic [CLS_W-1:0]  app_cls;
	logic [HW-1:0]     app_h;
	logic              app_en;
	logic              app_empty;
	logic [CMPW-1:0]   hin_ext;
	logic [MW-1:0]     left_m;
	logic [MW-1:0]     take_m;

	assign hin_ext    = CMPW'(block_handle);
	assign bad_handle = hin_q >= CMPW'(carved_q);
	assign left_m     = MW'(MAX_ENTRIES) - MW'(carved_q);
	assign take_m     = (left_m < MW'(REFILL_COUNT)) ? left_m : MW'(REFILL_COUNT);

	always_comb begin
		app_cls   = (state_q == S_FREE_CHK) ? cls_rd : cls_q;
		app_h     = (state_q == S_FREE_CHK) ? hin_q[HW-1:0] : carved_q[HW-1:0];
		app_en    = ((state_q == S_FREE_CHK) && !bad_handle) || (state_q == S_REFILL);
		app_empty = (len_q[app_cls] == '0);

		mem_ctl.link_we = app_en && !app_empty;
		mem_ctl.cls_we  = (state_q == S_REFILL);
		link_waddr = tail_q[app_cls];
		link_wdata = app_h;
		link_raddr = head_q[cls_q];
		cls_waddr  = carved_q[HW-1:0];
		cls_wdata  = cls_q;
		cls_raddr  = hin_ext[HW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			carved_q <= '0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				len_q[i]  <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						hin_q   <= hin_ext;
						state_q <= (command == CMD_FREE) ? S_FREE_CHK : S_SEL1;
					end
				end
				S_FREE_CHK: begin
					done_q   <= 1'b1;
					handle_q <= hin_q[HANDLE_W-1:0];
					if (bad_handle) begin
						status_q <= STAT_BAD_HANDLE;
						class_q  <= '0;
						size_q   <= '0;
					end else begin
						status_q <= STAT_OK;
						class_q  <= cls_rd;
						size_q   <= class_sizes[cls_rd];
					end
					state_q <= S_IDLE;
				end
				S_SEL1: begin
					state_q <= S_SEL2;
				end
				S_SEL2: begin
					found_q <= pick.vld;
					cls_q   <= pick.cls;
					best_q  <= pick.size;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (!found_q) begin
						done_q   <= 1'b1;
						status_q <= STAT_NO_FIT;
						handle_q <= '0;
						class_q  <= '0;
						size_q   <= '0;
						state_q  <= S_IDLE;
					end else if (len_q[cls_q] != '0) begin
						state_q <= S_POP;
					end else if (carved_q == CW'(MAX_ENTRIES)) begin
						done_q   <= 1'b1;
						status_q <= STAT_EXHAUSTED;
						handle_q <= '0;
						class_q  <= cls_q;
						size_q   <= best_q;
						state_q  <= S_IDLE;
					end else begin
						rem_q   <= take_m[RW-1:0];
						state_q <= S_REFILL;
					end
				end
				S_REFILL: begin
					carved_q <= carved_q + 1'b1;
					rem_q    <= rem_q - 1'b1;
					if (rem_q == RW'(1)) begin
						state_q <= S_DECIDE;
					end
				end
				S_POP: begin
					done_q        <= 1'b1;
					status_q      <= STAT_OK;
					handle_q      <= HANDLE_W'(CMPW'(head_q[cls_q]));
					class_q       <= cls_q;
					size_q        <= best_q;
					head_q[cls_q] <= link_rd;
					len_q[cls_q]  <= len_q[cls_q] - 1'b1;
					state_q       <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (app_en) begin
				if (app_empty) begin
					head_q[app_cls] <= app_h;
				end
				tail_q[app_cls] <= app_h;
				if (len_q[app_cls] != LEN_MAX) begin
					len_q[app_cls] <= len_q[app_cls] + 1'b1;
				end
			end
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign handle_out  = handle_q;
	assign class_index = class_q;
	assign class_size  = size_q;

endmodule

FILE: design/size_class_block_allocator_top.sv
// channel   | handshake               | word
// ----------+-------------------------+-----------------------------------------------
// command   | start, busy             | command, request_size, block_handle
// result    | done (one-cycle strobe) | status, handle_out, class_index, class_size
// config    | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// free: one entry-class memory read then the list update
// allocate: two-stage class select, then one link-memory read for the pop;
// no pop when no class fits or the pool is exhausted
// an allocate on an empty list first carves min(REFILL_COUNT, handles left)
// handles, one entry-class write each and a link-memory write for all but the first
// reset restores config defaults and clears list heads, tails, lengths and pool count; memories are not swept
// start is taken only while busy is low; results cannot be held off
`include "size_class_block_allocator_top_macros.svh"

module size_class_block_allocator_top #(
	parameter int MAX_ENTRIES  = scba_pkg::DEF_MAX_ENTRIES,
	parameter int REFILL_COUNT = scba_pkg::DEF_REFILL_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [31:0] request_size,
	input  logic [9:0]  block_handle,
	output logic        done,
	output logic [1:0]  status,
	output logic [9:0]  handle_out,
	output logic [1:0]  class_index,
	output logic [31:0] class_size,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import scba_pkg::*;

	localparam int HW = $clog2(MAX_ENTRIES);

	logic [CNT_W-1:0]     class_count_q;
	size_vec_t            class_sizes_q;
	logic [CFG_IDX_W-1:0] size_sel;
	cand_t                pick;
	mem_ctl_t             mem_ctl;
	logic [HW-1:0]        link_waddr;
	logic [HW-1:0]        link_wdata;
	logic [HW-1:0]        link_raddr;
	logic [HW-1:0]        link_rd;
	logic [HW-1:0]        cls_waddr;
	logic [CLS_W-1:0]     cls_wdata;
	logic [HW-1:0]        cls_raddr;
	logic [CLS_W-1:0]     cls_rd;

	assign cfg_ready = 1'b1;
	assign size_sel  = cfg_index - REG_CLASS_SIZE_0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= CLASS_COUNT_RST;
			class_sizes_q <= CLASS_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_CLASS_COUNT) begin
				class_count_q <= cfg_data[CNT_W-1:0];
			end else if (size_sel < CFG_IDX_W'(NUM_CLASSES)) begin
				class_sizes_q[size_sel[CLS_W-1:0]] <= cfg_data;
			end
		end
	end

	scba_select u_select (
		.clk          (clk),
		.request_size (request_size),
		.class_count  (class_count_q),
		.class_sizes  (class_sizes_q),
		.pick         (pick)
	);

	scba_store #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.HW          (HW)
	) u_store (
		.clk        (clk),
		.mem_ctl    (mem_ctl),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.link_raddr (link_raddr),
		.link_rd    (link_rd),
		.cls_waddr  (cls_waddr),
		.cls_wdata  (cls_wdata),
		.cls_raddr  (cls_raddr),
		.cls_rd     (cls_rd)
	);

	scba_ctrl #(
		.MAX_ENTRIES  (MAX_ENTRIES),
		.REFILL_COUNT (REFILL_COUNT),
		.HW           (HW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.command      (command),
		.block_handle (block_handle),
		.class_sizes  (class_sizes_q),
		.pick         (pick),
		.link_rd      (link_rd),
		.cls_rd       (cls_rd),
		.busy         (busy),
		.done         (done),
		.status       (status),
		.handle_out   (handle_out),
		.class_index  (class_index),
		.class_size   (class_size),
		.mem_ctl      (mem_ctl),
		.link_waddr   (link_waddr),
		.link_wdata   (link_wdata),
		.link_raddr   (link_raddr),
		.cls_waddr    (cls_waddr),
		.cls_wdata    (cls_wdata),
		.cls_raddr    (cls_raddr)
	);

	`SCBA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`SCBA_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy)
	`SCBA_ASSERT_SAME(a_done_after_busy, clk, arst_n, done, $past(busy))
	`SCBA_ASSERT_SAME(a_no_fit_zero, clk, arst_n, done && status == STAT_NO_FIT,
		handle_out == '0 && class_index == '0 && class_size == '0)

endmodule
